>>> sv/lkv_pkg.sv
// ---------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Holds the request and response payloads, the per-cell entry and sweep
// records, and the codes that steer the cell row.
// ---------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkv_req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } lkv_resp_t;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } lkv_entry_t;

    // Travels from the tail cell to the head cell, one cell per cycle.
    typedef struct packed {
        logic                    active;
        logic                    found;
        logic signed [VAL_W-1:0] value;
        logic                    tail_seen;
        logic signed [KEY_W-1:0] tail_key;
    } lkv_sweep_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_HIT,
        OP_FILL,
        OP_EVICT
    } lkv_op_t;

    typedef struct packed {
        lkv_op_t                 op;
        logic signed [KEY_W-1:0] key;
    } lkv_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } lkv_state_t;

endpackage

>>> sv/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// A request is a get (mode 0) or a put (mode 1) of a key, with a value for
// puts. Each request gives one response: hit, read value on a get hit, and
// the key of an entry evicted by a put.
// Entries sit in a row of cells ordered by recency, cell 0 most recent.
// A sweep record crosses the row from the tail to the head, one cell per
// cycle, collecting the hit, its value and the least recent key. The row
// then shifts to move the accessed entry to the head once the response register is free.
// One request is in flight at a time: a new request is taken only once
// the last one has finished its sweep through the cell row and its update.
// in_stall is high while a request is in flight. The response register
// holds while out_stall is high; a new request may be taken meanwhile, but
// its update waits until the held response is taken.
// Reset clears all valid marks, occupancy, and sets capacity to 16.
// The user must write capacity through cfg_write/cfg_data only while the
// block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module lru_key_value_cache
#(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  lkv_pkg::lkv_req_t         in_req,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lkv_pkg::lkv_resp_t        out_resp,
    input  logic                      cfg_write,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

    lkv_pkg::lkv_state_t       state_reg, state_next;
    logic                      start_reg, start_next;
    lkv_pkg::lkv_req_t         req_reg;
    lkv_pkg::lkv_sweep_t       fin_reg;
    logic [lkv_pkg::CAP_W-1:0] capacity_reg;
    logic [OCC_W-1:0]          occ_reg, occ_next;
    logic                      out_valid_reg, out_valid_next;
    lkv_pkg::lkv_resp_t        resp_reg, resp_next;

    lkv_pkg::lkv_ctrl_t        ctrl;
    lkv_pkg::lkv_entry_t       link [ENTRIES+1];
    lkv_pkg::lkv_sweep_t       sweep [ENTRIES+1];
    logic [ENTRIES-1:0]        valid_vec;

    logic                      accept;
    logic                      out_free;
    logic                      out_load;
    logic [CMP_W-1:0]          cap_ext, eff_cap;
    logic                      evict_cond;
    logic                      get_hit;

    assign in_stall  = (state_reg != lkv_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_resp  = resp_reg;

    // zero acts as one, anything above the row length acts as the row length
    always_comb
    begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign get_hit    = fin_reg.found && !req_reg.mode;
    assign evict_cond = !fin_reg.found && req_reg.mode && (CMP_W'(occ_reg) >= eff_cap);

    // head cell takes the accessed entry
    always_comb
    begin
        link[0].valid = 1'b1;
        link[0].key   = req_reg.key;
        link[0].value = get_hit ? fin_reg.value : req_reg.value;
    end

    always_comb
    begin
        sweep[ENTRIES]           = '0;
        sweep[ENTRIES].active    = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lkv_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .prev      (link[gi]),
                .entry     (link[gi+1]),
                .sweep_in  (sweep[gi+1]),
                .sweep_out (sweep[gi])
            );
            assign valid_vec[gi] = link[gi+1].valid;
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        out_load   = 1'b0;
        occ_next   = occ_reg;
        ctrl.key   = req_reg.key;
        ctrl.op    = lkv_pkg::OP_NONE;
        resp_next  = resp_reg;
        unique case (state_reg)
            lkv_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    start_next = 1'b1;
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN:
            begin
                if (sweep[0].active)
                begin
                    state_next = lkv_pkg::ST_APPLY;
                end
            end
            lkv_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = lkv_pkg::ST_IDLE;
                    if (fin_reg.found)
                        ctrl.op = lkv_pkg::OP_HIT;
                    else if (evict_cond)
                        ctrl.op = lkv_pkg::OP_EVICT;
                    else if (req_reg.mode)
                    begin
                        ctrl.op  = lkv_pkg::OP_FILL;
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    resp_next.hit         = fin_reg.found;
                    resp_next.read_value  = get_hit ? fin_reg.value : '0;
                    resp_next.evicted     = evict_cond;
                    resp_next.evicted_key = evict_cond ? fin_reg.tail_key : '0;
                end
            end
            default:
            begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::ST_IDLE;
            start_reg     <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= lkv_pkg::CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
        if (accept)
        begin
            req_reg <= in_req;
        end
        if (state_reg == lkv_pkg::ST_SCAN && sweep[0].active)
        begin
            fin_reg <= sweep[0];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
    else $error("valid marks disagree with occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= ENTRIES)
    else $error("occupancy above row length");

    assert property (@(posedge clk) disable iff (!rst_n)
        sweep[0].active |-> state_reg == lkv_pkg::ST_SCAN)
    else $error("sweep finished outside scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkv_pkg::ST_APPLY && out_free) |=> out_valid_reg)
    else $error("applied request lost its response");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(resp_reg.hit && resp_reg.evicted))
    else $error("hit and eviction in one response");

endmodule

>>> sv/lkv_cell.sv
// ---------------------------------------------------------------------------
// lkv_cell: one slot of the recency-ordered entry row
// Compares its key against the request, folds its contribution into the
// passing sweep record, and on an update shifts in its neighbor's entry.
// ---------------------------------------------------------------------------
module lkv_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  lkv_pkg::lkv_ctrl_t ctrl,
    input  lkv_pkg::lkv_entry_t prev,
    output lkv_pkg::lkv_entry_t entry,
    input  lkv_pkg::lkv_sweep_t sweep_in,
    output lkv_pkg::lkv_sweep_t sweep_out
);

    logic                             valid_reg;
    logic signed [lkv_pkg::KEY_W-1:0] key_reg;
    logic signed [lkv_pkg::VAL_W-1:0] value_reg;
    logic                             below_hit_reg;
    logic                             active_reg;
    lkv_pkg::lkv_sweep_t              sweep_reg;
    lkv_pkg::lkv_sweep_t              sweep_next;
    logic                             match;
    logic                             take;

    assign match = valid_reg && (key_reg == ctrl.key);

    always_comb
    begin
        sweep_next.active    = sweep_in.active;
        sweep_next.found     = sweep_in.found | match;
        sweep_next.value     = match ? value_reg : sweep_in.value;
        sweep_next.tail_seen = sweep_in.tail_seen | valid_reg;
        // first valid cell seen from the tail is the least recent entry
        sweep_next.tail_key  = (!sweep_in.tail_seen && valid_reg) ? key_reg
                                                                  : sweep_in.tail_key;
    end

    always_comb
    begin
        case (ctrl.op)
            lkv_pkg::OP_HIT:   take = below_hit_reg;
            lkv_pkg::OP_FILL:  take = prev.valid;
            lkv_pkg::OP_EVICT: take = valid_reg;
            default:           take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= sweep_in.active;
            if (take)
            begin
                valid_reg <= prev.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        if (take)
        begin
            key_reg   <= prev.key;
            value_reg <= prev.value;
        end
        // remember whether the hit sits at or behind this cell
        if (sweep_in.active)
        begin
            below_hit_reg <= sweep_next.found;
        end
    end

    always_comb
    begin
        sweep_out        = sweep_reg;
        sweep_out.active = active_reg;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule
